// ----- rtl/nchb_pkg.sv -----
`default_nettype none
package nchb_pkg;

  // Stack depth default; the top level takes it as a parameter.
  localparam int unsigned MAX_DEPTH = 16;

  localparam logic [31:0] CHUNK_HDR_BYTES = 32'd8;
  localparam logic [31:0] MINI_HDR_BYTES  = 32'd2;
  localparam logic [31:0] MINI_LIMIT      = 32'h0000_00FF;

  // APB register map: one 32-bit register per word.
  localparam int unsigned PADDR_W = 3;
  localparam logic [0:0]  REG_START_POSITION = 1'b0;

  typedef enum logic [1:0] {
    CMD_BEGIN      = 2'd0,
    CMD_BEGIN_MINI = 2'd1,
    CMD_END        = 2'd2,
    CMD_DATA       = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK        = 2'd0,
    KIND_CHUNK_PATCH = 2'd1,
    KIND_MINI_PATCH = 2'd2,
    KIND_ERROR      = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_DEPTH         = 3'd1,
    ERR_NOTHING_OPEN  = 3'd2,
    ERR_MINI_OPEN     = 3'd3,
    ERR_MINI_TYPE     = 3'd4,
    ERR_MINI_SIZE     = 3'd5
  } err_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] chunk_type;
    logic [15:0] data_len;
  } req_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [31:0] patch_offset;
    logic [31:0] patch_type;
    logic [31:0] patch_size;
    err_t        error_code;
    logic [31:0] position_now;
  } res_t;

  // One stack entry below the top of stack.
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] ctype;
    logic        container;
  } entry_t;

endpackage
`default_nettype wire

// ----- rtl/nested_chunk_header_backpatcher_unit.sv -----
`default_nettype none
// Nested chunk header back-patcher. Tracks a 32-bit byte write position
// (wrapping) and a stack of up to MAX_DEPTH open chunks plus one open
// mini-chunk. Each request (begin chunk, begin mini-chunk, end, data) gives
// exactly one result: an acknowledge, a chunk or mini-chunk header patch
// (offset, type, body size; chunk sizes carry the container flag in bit 31),
// or an error with its code and no state change (a mini-chunk whose size
// exceeds 255 is closed and dropped). position_now is the position after
// the request. One request is taken per clock; its result is registered. A
// two-entry output (result register plus skid register) lets requests keep
// flowing while a result waits, and req_ready drops only when both entries
// are full. The top of stack lives in flops; entries below it sit in a
// MAX_DEPTH-entry memory whose registered read port always holds the entry
// just below the top, with write-through when that entry is written in the
// same cycle, so an end request never waits on the memory. No clearing
// pass after reset. The start_position register (APB byte address 0) loads
// the write position when written; write it only while the block is idle.
module nested_chunk_header_backpatcher_unit #(
  parameter int unsigned MAX_DEPTH = nchb_pkg::MAX_DEPTH
) (
  input  wire                          clk,
  input  wire                          rst,
  // request channel
  input  wire                          req_valid,
  output logic                         req_ready,
  input  nchb_pkg::req_t               req_data,
  // result channel
  output logic                         res_valid,
  input  wire                          res_ready,
  output nchb_pkg::res_t               res_data,
  // configuration port
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [nchb_pkg::PADDR_W-1:0]  paddr,
  input  wire [31:0]                   pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned CNT_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // Architectural state
  logic [31:0]      start_position;
  logic [31:0]      write_position, write_position_next;
  logic [CNT_W-1:0] open_count, open_count_next;
  logic             mini_open, mini_open_next;
  logic [31:0]      mini_start, mini_start_next;
  logic [7:0]       mini_type, mini_type_next;

  // Top of stack, held in flops
  logic [31:0]      top_start, top_start_next;
  logic [31:0]      top_type, top_type_next;
  logic             top_flag, top_flag_next;

  // Entries below the top
  nchb_pkg::entry_t stack_mem [MAX_DEPTH];
  nchb_pkg::entry_t below;           // registered read: entry under the top
  logic             st_we;
  logic [IDX_W-1:0] st_waddr;
  logic [IDX_W-1:0] st_raddr;
  nchb_pkg::entry_t st_wdata;
  logic [CNT_W-1:0] cnt_dec, rd_ptr;

  // Output register plus skid
  nchb_pkg::res_t   res_reg, skid_reg, res;
  logic             skid_valid;

  logic             accept, pop, cfg_wr;
  logic [31:0]      size_calc;

  assign accept    = req_valid && req_ready;
  assign pop       = res_valid && res_ready;
  assign req_ready = !skid_valid;
  assign res_data  = res_reg;

  // APB: always ready, single register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == nchb_pkg::REG_START_POSITION);
  assign prdata = (paddr[2] == nchb_pkg::REG_START_POSITION) ? start_position : 32'd0;

  assign cnt_dec  = open_count - CNT_W'(1);
  assign st_waddr = cnt_dec[IDX_W-1:0];
  // Keep the read port aimed at the entry under the next top of stack.
  assign rd_ptr   = open_count_next - CNT_W'(2);
  assign st_raddr = rd_ptr[IDX_W-1:0];

  // Request decode and next state
  always_comb begin
    write_position_next = write_position;
    open_count_next     = open_count;
    mini_open_next      = mini_open;
    mini_start_next     = mini_start;
    mini_type_next      = mini_type;
    top_start_next      = top_start;
    top_type_next       = top_type;
    top_flag_next       = top_flag;
    st_we               = 1'b0;
    st_wdata            = '{start: top_start, ctype: top_type, container: 1'b1};
    size_calc           = 32'd0;

    res              = '0;
    res.result_kind  = nchb_pkg::KIND_ACK;
    res.error_code   = nchb_pkg::ERR_NONE;

    if (accept) begin
      unique case (req_data.cmd)
        nchb_pkg::CMD_BEGIN: begin
          if (open_count == CNT_W'(MAX_DEPTH)) begin
            res.result_kind = nchb_pkg::KIND_ERROR;
            res.error_code  = nchb_pkg::ERR_DEPTH;
          end else begin
            // old top goes down into memory, now marked as a container
            st_we               = (open_count != '0);
            top_start_next      = write_position;
            top_type_next       = req_data.chunk_type;
            top_flag_next       = 1'b0;
            open_count_next     = open_count + CNT_W'(1);
            write_position_next = write_position + nchb_pkg::CHUNK_HDR_BYTES;
          end
        end
        nchb_pkg::CMD_BEGIN_MINI: begin
          priority if (open_count == '0) begin
            res.result_kind = nchb_pkg::KIND_ERROR;
            res.error_code  = nchb_pkg::ERR_NOTHING_OPEN;
          end else if (mini_open) begin
            res.result_kind = nchb_pkg::KIND_ERROR;
            res.error_code  = nchb_pkg::ERR_MINI_OPEN;
          end else if (req_data.chunk_type > nchb_pkg::MINI_LIMIT) begin
            res.result_kind = nchb_pkg::KIND_ERROR;
            res.error_code  = nchb_pkg::ERR_MINI_TYPE;
          end else begin
            mini_open_next      = 1'b1;
            mini_start_next     = write_position;
            mini_type_next      = req_data.chunk_type[7:0];
            write_position_next = write_position + nchb_pkg::MINI_HDR_BYTES;
          end
        end
        nchb_pkg::CMD_DATA: begin
          if (open_count == '0) begin
            res.result_kind = nchb_pkg::KIND_ERROR;
            res.error_code  = nchb_pkg::ERR_NOTHING_OPEN;
          end else begin
            write_position_next = write_position + {16'd0, req_data.data_len};
          end
        end
        nchb_pkg::CMD_END: begin
          priority if (open_count == '0) begin
            res.result_kind = nchb_pkg::KIND_ERROR;
            res.error_code  = nchb_pkg::ERR_NOTHING_OPEN;
          end else if (mini_open) begin
            // mini closes either way; oversize drops it
            size_calc      = write_position - (mini_start + nchb_pkg::MINI_HDR_BYTES);
            mini_open_next = 1'b0;
            if (size_calc > nchb_pkg::MINI_LIMIT) begin
              res.result_kind = nchb_pkg::KIND_ERROR;
              res.error_code  = nchb_pkg::ERR_MINI_SIZE;
            end else begin
              res.result_kind  = nchb_pkg::KIND_MINI_PATCH;
              res.patch_offset = mini_start;
              res.patch_type   = {24'd0, mini_type};
              res.patch_size   = size_calc;
            end
          end else begin
            size_calc        = write_position - (top_start + nchb_pkg::CHUNK_HDR_BYTES);
            res.result_kind  = nchb_pkg::KIND_CHUNK_PATCH;
            res.patch_offset = top_start;
            res.patch_type   = top_type;
            res.patch_size   = {top_flag, size_calc[30:0]};
            open_count_next  = cnt_dec;
            top_start_next   = below.start;
            top_type_next    = below.ctype;
            top_flag_next    = below.container;
          end
        end
        default: begin
          res.result_kind = nchb_pkg::KIND_ACK;
        end
      endcase
    end

    res.position_now = write_position_next;
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= 32'd0;
      write_position <= 32'd0;
      open_count     <= '0;
      mini_open      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        start_position <= pwdata;
        write_position <= pwdata;
      end else begin
        write_position <= write_position_next;
      end
      open_count <= open_count_next;
      mini_open  <= mini_open_next;
    end
  end

  // Payload state, no reset needed
  always_ff @(posedge clk) begin
    mini_start <= mini_start_next;
    mini_type  <= mini_type_next;
    top_start  <= top_start_next;
    top_type   <= top_type_next;
    top_flag   <= top_flag_next;
  end

  // Stack memory with write-through on the read port
  always_ff @(posedge clk) begin
    if (st_we) begin
      stack_mem[st_waddr] <= st_wdata;
    end
    if (st_we && (st_waddr == st_raddr)) begin
      below <= st_wdata;
    end else begin
      below <= stack_mem[st_raddr];
    end
  end

  // Result register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (skid_valid) begin
        if (pop) begin
          skid_valid <= 1'b0;
        end
      end else if (accept) begin
        if (res_valid && !pop) begin
          skid_valid <= 1'b1;
        end else begin
          res_valid <= 1'b1;
        end
      end else begin
        if (pop) begin
          res_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (skid_valid) begin
      if (pop) begin
        res_reg <= skid_reg;
      end
    end else begin
      if (accept) begin
        if (res_valid && !pop) begin
          skid_reg <= res;
        end else begin
          res_reg <= res;
        end
      end
    end
  end

endmodule
`default_nettype wire
